### sv/plel_pkg.sv
// ----------------------------------------------------------------------------
// plel_pkg
// Shared types and constants for the positional list engine: request codes,
// result status codes, sequencer states and the fixed field widths.
// ----------------------------------------------------------------------------
package plel_pkg;

  localparam int unsigned POS_W  = 9;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_DRAIN = 2'd2,
    S_PUT   = 2'd3
  } state_t;

endpackage

### sv/plel_ram.sv
// ----------------------------------------------------------------------------
// plel_ram
// Single-clock list storage: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module plel_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [plel_pkg::DATA_W-1:0]      wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic [plel_pkg::DATA_W-1:0]      rdata
);

  logic [plel_pkg::DATA_W-1:0] mem [DEPTH];
  logic [plel_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed 32-bit values, addressed by 1-based
// position, held in a single-port-read, single-port-write memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with out_valid, and busy is already low in that
// cycle, so a new request may be given then. Requests that need no memory
// access (errors, clear, unused codes, locate on an empty list) return their
// result in the cycle after acceptance. The others walk the memory one entry
// per cycle through its single read port, with the read of the next entry
// overlapped with the write-back of the previous one. Entries that were
// never written are never read.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [plel_pkg::OP_W-1:0]           in_op,
  input  logic [plel_pkg::POS_W-1:0]          in_position,
  input  logic signed [plel_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic [plel_pkg::STAT_W-1:0]         out_status,
  output logic signed [plel_pkg::DATA_W-1:0]  out_read_value,
  output logic [plel_pkg::POS_W-1:0]          out_found_position,
  output logic [plel_pkg::POS_W-1:0]          out_length
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > plel_pkg::POS_W) ? CW : plel_pkg::POS_W) + 1;

  plel_pkg::state_t  state_r, state_nxt;
  plel_pkg::op_t     op_r, op_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [plel_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [plel_pkg::DATA_W-1:0] rv_r, rv_nxt;

  logic                        out_valid_r, out_valid_nxt;
  plel_pkg::status_t           status_r, status_nxt;
  logic [plel_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [plel_pkg::POS_W-1:0]  found_r, found_nxt;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [plel_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

  logic [PW-1:0] pos_ext, cnt_ext;
  logic          ins_ok, acc_ok, full, hit, cap;

  plel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign pos_ext = PW'(in_position);
  assign cnt_ext = PW'(count_r);
  assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + PW'(1));
  assign acc_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign full    = (count_r == CW'(DEPTH));

  // Data returned by last cycle's read is handled before the state decode.
  assign hit = rd_pend_r && (op_r == plel_pkg::OP_LOCATE) && (mem_rdata == val_r);
  assign cap = rd_pend_r && ((op_r == plel_pkg::OP_GET) ||
                             ((op_r == plel_pkg::OP_DELETE) && (rd_addr_r == k_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plel_pkg::S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ptr_r     <= ptr_nxt;
    end_r     <= end_nxt;
    k_r       <= k_nxt;
    rd_addr_r <= rd_addr_nxt;
    val_r     <= val_nxt;
    rv_r      <= rv_nxt;
    status_r  <= status_nxt;
    value_r   <= value_nxt;
    found_r   <= found_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    k_nxt         = k_r;
    rd_addr_nxt   = ptr_r;
    rd_pend_nxt   = 1'b0;
    val_nxt       = val_r;
    rv_nxt        = rv_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    value_nxt     = value_r;
    found_nxt     = found_r;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;
    mem_we        = 1'b0;
    mem_waddr     = rd_addr_r;
    mem_wdata     = mem_rdata;

    // Shifting: insert moves each entry up by one, delete moves it down.
    if (rd_pend_r && (op_r == plel_pkg::OP_INSERT)) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_r + AW'(1);
    end
    if (rd_pend_r && (op_r == plel_pkg::OP_DELETE) && (rd_addr_r != k_r)) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_r - AW'(1);
    end
    if (cap) begin
      rv_nxt = mem_rdata;
    end

    unique case (state_r)
      plel_pkg::S_IDLE: begin
        if (start) begin
          op_nxt        = plel_pkg::op_t'(in_op);
          k_nxt         = AW'(pos_ext - PW'(1));
          val_nxt       = in_value;
          out_valid_nxt = 1'b1;
          status_nxt    = plel_pkg::ST_OK;
          value_nxt     = '0;
          found_nxt     = '0;
          unique case (plel_pkg::op_t'(in_op)) inside
            plel_pkg::OP_INSERT: begin
              if (!ins_ok) begin
                status_nxt = plel_pkg::ST_BADPOS;
              end else if (full) begin
                status_nxt = plel_pkg::ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                ptr_nxt       = AW'(cnt_ext - PW'(1));
                end_nxt       = AW'(pos_ext - PW'(1));
                if (pos_ext == cnt_ext + PW'(1)) begin
                  state_nxt = plel_pkg::S_PUT;
                end else begin
                  state_nxt = plel_pkg::S_SCAN;
                end
              end
            end
            plel_pkg::OP_DELETE, plel_pkg::OP_GET: begin
              if (!acc_ok) begin
                status_nxt = plel_pkg::ST_BADPOS;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = plel_pkg::S_SCAN;
                ptr_nxt       = AW'(pos_ext - PW'(1));
                if (plel_pkg::op_t'(in_op) == plel_pkg::OP_DELETE) begin
                  end_nxt = AW'(cnt_ext - PW'(1));
                end else begin
                  end_nxt = AW'(pos_ext - PW'(1));
                end
              end
            end
            plel_pkg::OP_LOCATE: begin
              if (count_r == '0) begin
                status_nxt = plel_pkg::ST_NOTFOUND;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = plel_pkg::S_SCAN;
                ptr_nxt       = '0;
                end_nxt       = AW'(cnt_ext - PW'(1));
              end
            end
            plel_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // Unused codes only report the length.
            end
          endcase
        end
      end

      plel_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt     = plel_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = plel_pkg::ST_OK;
          found_nxt     = plel_pkg::POS_W'(CW'(rd_addr_r) + CW'(1));
        end else begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_addr_nxt = ptr_r;
          if (ptr_r == end_r) begin
            state_nxt = plel_pkg::S_DRAIN;
          end else if (op_r == plel_pkg::OP_INSERT) begin
            ptr_nxt = ptr_r - AW'(1);
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end

      plel_pkg::S_DRAIN: begin
        state_nxt = plel_pkg::S_IDLE;
        case (op_r)
          plel_pkg::OP_INSERT: begin
            state_nxt = plel_pkg::S_PUT;
          end
          plel_pkg::OP_LOCATE: begin
            out_valid_nxt = 1'b1;
            if (hit) begin
              status_nxt = plel_pkg::ST_OK;
              found_nxt  = plel_pkg::POS_W'(CW'(rd_addr_r) + CW'(1));
            end else begin
              status_nxt = plel_pkg::ST_NOTFOUND;
            end
          end
          plel_pkg::OP_DELETE: begin
            out_valid_nxt = 1'b1;
            count_nxt     = count_r - CW'(1);
            value_nxt     = cap ? mem_rdata : rv_r;
          end
          default: begin
            // Get: the entry arrives now.
            out_valid_nxt = 1'b1;
            value_nxt     = mem_rdata;
          end
        endcase
      end

      plel_pkg::S_PUT: begin
        mem_we        = 1'b1;
        mem_waddr     = k_r;
        mem_wdata     = val_r;
        count_nxt     = count_r + CW'(1);
        state_nxt     = plel_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
      end

      default: begin
        state_nxt = plel_pkg::S_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != plel_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_read_value     = value_r;
  assign out_found_position = found_r;
  assign out_length         = plel_pkg::POS_W'(count_r);

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("list length exceeds depth");

  a_result_frees : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result beat while the engine is still busy");

  a_accept_progress : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("accepted request neither started nor answered");

  a_idle_no_read : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plel_pkg::S_IDLE) |-> !rd_pend_r)
    else $error("read data pending while idle");

  a_length_with_result : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> out_valid_r)
    else $error("length changed without a result beat");

endmodule

### dv/list_result_checker.sv
// ----------------------------------------------------------------------------
// list_result_checker
// Watches the request and result channels of the positional list engine. It
// keeps its own copy of the list, works out the result of every accepted
// request and compares each result beat, field by field, with the oldest
// outstanding expectation.
// ----------------------------------------------------------------------------
module list_result_checker #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [plel_pkg::OP_W-1:0]           in_op,
  input  logic [plel_pkg::POS_W-1:0]          in_position,
  input  logic signed [plel_pkg::DATA_W-1:0]  in_value,
  input  logic                                out_valid,
  input  logic [plel_pkg::STAT_W-1:0]         out_status,
  input  logic signed [plel_pkg::DATA_W-1:0]  out_read_value,
  input  logic [plel_pkg::POS_W-1:0]          out_found_position,
  input  logic [plel_pkg::POS_W-1:0]          out_length,
  output int                                  fail_count,
  output int                                  pending
);
  import plel_pkg::*;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [POS_W-1:0]          found_pos;
    logic [POS_W-1:0]          length;
  } list_result_t;

  // Two-state counters start at zero, so no separate initialisation is kept.
  logic signed [DATA_W-1:0] slots [DEPTH];
  int unsigned              held_len;
  list_result_t             awaited_results [$];
  int                       mismatches;

  function automatic list_result_t apply_list_request(logic [OP_W-1:0] op,
                                                      logic [POS_W-1:0] pos,
                                                      logic signed [DATA_W-1:0] val);
    list_result_t r;
    int unsigned  p;
    bit           hit;
    r.status     = ST_OK;
    r.read_value = '0;
    r.found_pos  = '0;
    p            = pos;
    hit          = 1'b0;
    case (op)
      OP_INSERT: begin
        // The position check takes precedence over the full check.
        if (p < 1 || p > held_len + 1) begin
          r.status = ST_BADPOS;
        end else if (held_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned i = held_len; i > p - 1; i--) slots[i] = slots[i - 1];
          slots[p - 1] = val;
          held_len++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > held_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = slots[p - 1];
          for (int unsigned i = p - 1; i + 1 < held_len; i++) slots[i] = slots[i + 1];
          held_len--;
        end
      end
      OP_GET: begin
        if (p < 1 || p > held_len) r.status = ST_BADPOS;
        else r.read_value = slots[p - 1];
      end
      OP_LOCATE: begin
        for (int unsigned i = 0; i < held_len && !hit; i++) begin
          if (slots[i] == val) begin
            hit         = 1'b1;
            r.found_pos = POS_W'(i + 1);
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      OP_CLEAR: held_len = 0;
      default: ;
    endcase
    r.length = POS_W'(held_len);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      held_len = 0;
      awaited_results.delete();
    end else begin
      // A result beat is matched before a request accepted at the same edge
      // is predicted, since it can only belong to an earlier request.
      if (out_valid === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value,
                   out_read_value);
            mismatches++;
          end
          if (out_found_position !== want.found_pos) begin
            $error("found_position: expected %0d, actual %0d", want.found_pos,
                   out_found_position);
            mismatches++;
          end
          if (out_length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, out_length);
            mismatches++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        awaited_results.push_back(apply_list_request(in_op, in_position, in_value));
    end
    fail_count <= mismatches;
    pending    <= awaited_results.size();
  end

endmodule

### dv/positional_list_engine_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives requests into the positional list engine: a directed opening over
// the empty list, the list ends, duplicates and unused codes, then random
// phases that grow, shrink and churn the list, fill it to capacity twice and
// throw in malformed requests. Checking is done by list_result_checker.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import plel_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int          ITEM_TARGET = 2000;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          MAX_GAP     = 11;
  localparam int          POOL_SIZE   = 16;

  localparam logic [OP_W-1:0]          OP_CODE_TOP = {OP_W{1'b1}};
  localparam logic [POS_W-1:0]         POS_TOP     = {POS_W{1'b1}};
  localparam logic signed [DATA_W-1:0] DATA_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BLEND, MIX_NOISE} mix_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     start       = 1'b0;
  logic [OP_W-1:0]          in_op       = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     busy;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_read_value;
  logic [POS_W-1:0]         out_found_position;
  logic [POS_W-1:0]         out_length;

  int                       result_failures;
  int                       pending_results;
  int                       cycles = 0;
  int unsigned              tracked_len = 0;
  int                       items_sent = 0;
  bit                       idle_on = 1'b1;
  bit                       refilled = 1'b0;
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

  positional_list_engine #(.DEPTH(DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_length         (out_length)
  );

  list_result_checker #(.DEPTH(DEPTH)) result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_length         (out_length),
    .fail_count         (result_failures),
    .pending            (pending_results)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("positional_list_engine regression: fail");
      $finish;
    end
  end

  // A small pool of recurring values makes locate hits and duplicates common.
  function automatic logic signed [DATA_W-1:0] draw_value();
    int slot;
    slot = $urandom_range(0, POOL_SIZE - 1);
    if ($urandom_range(0, 9) == 0) value_pool[slot] = $urandom;
    if ($urandom_range(0, 9) < 6) return value_pool[slot];
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] insert_pos();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return POS_W'(1);
    if (roll == 1) return POS_W'(tracked_len + 1);
    return POS_W'($urandom_range(1, tracked_len + 1));
  endfunction

  // Holds the request until the edge at which busy is low, then returns in
  // that same time step so that a back-to-back request keeps start high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    items_sent++;
    case (op)
      OP_INSERT: if (pos >= 1 && pos <= tracked_len + 1 && tracked_len < DEPTH) tracked_len++;
      OP_DELETE: if (pos >= 1 && pos <= tracked_len) tracked_len--;
      OP_CLEAR:  tracked_len = 0;
      default: ;
    endcase
  endtask

  // Grows the list to capacity, then probes the full list.
  task automatic fill_list();
    int roll;
    while (tracked_len < DEPTH) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) send_request(OP_INSERT, insert_pos(), draw_value());
      else if (roll < 93) send_request(OP_LOCATE, '0, draw_value());
      else send_request(OP_GET, POS_W'($urandom_range(1, tracked_len)), '0);
    end
    send_request(OP_INSERT, POS_W'(DEPTH + 1), draw_value());
    send_request(OP_INSERT, POS_W'(DEPTH + 2), draw_value());
    send_request(OP_INSERT, POS_W'(1), draw_value());
    send_request(OP_GET, POS_W'(DEPTH), '0);
    send_request(OP_LOCATE, '0, $urandom);
    send_request(OP_DELETE, POS_W'(DEPTH), '0);
    send_request(OP_INSERT, POS_W'(DEPTH), draw_value());
  endtask

  task automatic run_mix(input mix_t kind, input int n);
    int               roll;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      op   = OP_GET;
      pos  = (tracked_len == 0) ? POS_W'(1) : POS_W'($urandom_range(1, tracked_len));
      case (kind)
        MIX_GROW: begin
          if (roll < 70) begin
            op  = OP_INSERT;
            pos = insert_pos();
          end else if (roll < 80) op = OP_GET;
          else if (roll < 90) op = OP_LOCATE;
          else if (roll < 95) op = OP_DELETE;
          else begin
            op  = OP_INSERT;
            pos = POS_W'($urandom_range(0, POS_TOP));
          end
        end
        MIX_SHRINK: begin
          if (roll < 65) op = OP_DELETE;
          else if (roll < 75) op = OP_GET;
          else if (roll < 85) op = OP_LOCATE;
          else if (roll < 90) begin
            op  = OP_INSERT;
            pos = insert_pos();
          end else if (roll < 93) op = OP_CLEAR;
          else begin
            op  = OP_DELETE;
            pos = POS_W'($urandom_range(tracked_len + 1, POS_TOP));
          end
        end
        MIX_BLEND: begin
          if (roll < 35) begin
            op  = OP_INSERT;
            pos = insert_pos();
          end else if (roll < 60) op = OP_DELETE;
          else if (roll < 75) op = OP_GET;
          else if (roll < 90) op = OP_LOCATE;
          else if (roll < 93) op = OP_CLEAR;
          else if (roll < 97) begin
            pos = $urandom_range(0, 1) ? '0
                                       : POS_W'($urandom_range(tracked_len + 1, POS_TOP));
          end else op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, OP_CODE_TOP));
        end
        default: begin
          op  = OP_W'($urandom_range(0, OP_CODE_TOP));
          pos = POS_W'($urandom_range(0, POS_TOP));
        end
      endcase
      send_request(op, pos, draw_value());
    end
  endtask

  initial begin
    value_pool[0] = DATA_MIN;
    value_pool[1] = DATA_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: every position is out of range and locate finds nothing.
    send_request(OP_GET, POS_W'(1), '0);
    send_request(OP_DELETE, POS_W'(1), '0);
    send_request(OP_LOCATE, '0, '0);
    send_request(OP_INSERT, '0, DATA_MAX);
    send_request(OP_INSERT, POS_W'(2), DATA_MAX);
    // Build min, 0, max, -1 using head, tail and middle inserts.
    send_request(OP_INSERT, POS_W'(1), DATA_MAX);
    send_request(OP_INSERT, POS_W'(1), DATA_MIN);
    send_request(OP_INSERT, POS_W'(3), -1);
    send_request(OP_INSERT, POS_W'(2), '0);
    send_request(OP_GET, POS_W'(1), '0);
    send_request(OP_GET, POS_W'(4), '0);
    send_request(OP_GET, POS_W'(5), '0);
    send_request(OP_GET, '0, '0);
    send_request(OP_LOCATE, '0, -1);
    send_request(OP_LOCATE, '0, 32'sh1234_5678);
    send_request(OP_W'(int'(OP_CLEAR) + 1), POS_TOP, -1);
    send_request(OP_W'(int'(OP_CLEAR) + 2), POS_W'(1), DATA_MIN);
    send_request(OP_CODE_TOP, POS_W'(2), DATA_MAX);
    // A duplicate at the tail: locate must report the first copy.
    send_request(OP_INSERT, POS_W'(5), DATA_MAX);
    send_request(OP_LOCATE, '0, DATA_MAX);
    send_request(OP_DELETE, POS_W'(2), '0);
    send_request(OP_DELETE, POS_W'(5), '0);
    send_request(OP_GET, POS_TOP, '0);
    send_request(OP_DELETE, POS_W'(4), '0);
    send_request(OP_CLEAR, '0, '0);
    send_request(OP_GET, POS_W'(1), '0);

    fill_list();
    while (items_sent < ITEM_TARGET) begin
      if (!refilled && items_sent > ITEM_TARGET / 2) begin
        fill_list();
        refilled = 1'b1;
      end
      idle_on = ($urandom_range(0, 3) != 0);
      run_mix(mix_t'($urandom_range(0, 3)), $urandom_range(20, 80));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    @(negedge clk);
    if (result_failures == 0) $display("positional_list_engine regression: pass");
    else $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule
